@@ src/ptpyp_pkg.sv @@
// shared types, constants and angle table for the point-to-point yaw/pitch block
package ptpyp_pkg;

    // datapath word for the cordic x/y lanes and the angle accumulator width
    localparam int WORD_W = 64;
    localparam int ANG_W  = 32;

    // cordic gain in q24, 180 degrees in 2^-16 degree units, output clamps
    localparam logic [25:0]        GAIN_Q24    = 26'd27628053;
    localparam logic signed [31:0] DEG180_Q16  = 32'sd11796480;
    localparam logic signed [31:0] YAW_LIMIT   = 32'sd23040;
    localparam logic signed [31:0] PITCH_LIMIT = 32'sd11520;
    localparam int                 TABLE_LEN   = 24;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [ANG_W-1:0]  angle_t;

    // one cordic lane between stages
    typedef struct packed {
        word_t  x;
        word_t  y;
        angle_t z;
    } cordic_state_t;

    // atan(2^-i) in degrees times 65536, rounded to nearest
    function automatic angle_t atan_q16(input int idx);
        angle_t r;
        case (idx)
            0:  r = 32'sd2949120;
            1:  r = 32'sd1740967;
            2:  r = 32'sd919879;
            3:  r = 32'sd466945;
            4:  r = 32'sd234379;
            5:  r = 32'sd117304;
            6:  r = 32'sd58666;
            7:  r = 32'sd29335;
            8:  r = 32'sd14668;
            9:  r = 32'sd7334;
            10: r = 32'sd3667;
            11: r = 32'sd1833;
            12: r = 32'sd917;
            13: r = 32'sd458;
            14: r = 32'sd229;
            15: r = 32'sd115;
            16: r = 32'sd57;
            17: r = 32'sd29;
            18: r = 32'sd14;
            19: r = 32'sd7;
            20: r = 32'sd4;
            21: r = 32'sd2;
            22: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

endpackage

@@ src/ptpyp_cordic_stage.sv @@
// one registered vectoring cordic micro-rotation
module ptpyp_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  ptpyp_pkg::cordic_state_t in_state,
    output logic                    out_valid,
    output ptpyp_pkg::cordic_state_t out_state
);

    ptpyp_pkg::cordic_state_t state_next;
    ptpyp_pkg::cordic_state_t state_reg;
    logic                     valid_reg;
    ptpyp_pkg::word_t         xs;
    ptpyp_pkg::word_t         ys;

    // rotate toward y = 0, shifts round toward minus infinity
    always_comb begin
        xs = in_state.x >>> STEP;
        ys = in_state.y >>> STEP;
        if (in_state.y > 0) begin
            state_next.x = in_state.x + ys;
            state_next.y = in_state.y - xs;
            state_next.z = in_state.z + ptpyp_pkg::atan_q16(STEP);
        end else begin
            state_next.x = in_state.x - ys;
            state_next.y = in_state.y + xs;
            state_next.z = in_state.z - ptpyp_pkg::atan_q16(STEP);
        end
    end

    // valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // lane payload
    always_ff @(posedge aclk) begin
        if (en) begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

@@ src/point_to_point_yaw_pitch.sv @@
// top level: difference vector, yaw cordic, pitch cordic, rounding and clamp
// register order from accepted input word to output word: difference, prep, yaw stages, pitch stages, output
// throughput: one word per cycle unless the output stalls; each micro-rotation is its own register stage
// a stall at the output freezes the whole pipeline, nothing is lost or repeated
// reset (aresetn low, synchronous) clears all valid bits; payload is not reset
module point_to_point_yaw_pitch #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_WIDTH  = 24
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, start_z, target_x, target_y, target_z from bit 0 up
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // yaw_angle[15:0], pitch_angle[30:16], zero fill
    output logic [31:0]             m_tdata
);

    localparam int W     = COORD_WIDTH;
    localparam int N     = CORDIC_STEPS;
    localparam int PW    = W + 28;
    localparam int XSH   = 56 - W;
    localparam int VSH   = 32 - W;

    logic adv;

    // stage 0: difference vector
    logic                valid0_reg;
    logic signed [W:0]   dx_reg, dy_reg, dz_reg;
    logic signed [W-1:0] sx, sy, sz, tx, ty, tz;

    assign sx = $signed(s_tdata[0*W +: W]);
    assign sy = $signed(s_tdata[1*W +: W]);
    assign sz = $signed(s_tdata[2*W +: W]);
    assign tx = $signed(s_tdata[3*W +: W]);
    assign ty = $signed(s_tdata[4*W +: W]);
    assign tz = $signed(s_tdata[5*W +: W]);

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid0_reg <= 1'b0;
        end else if (adv) begin
            valid0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dx_reg <= (W+1)'(tx) - (W+1)'(sx);
            dy_reg <= (W+1)'(ty) - (W+1)'(sy);
            dz_reg <= (W+1)'(tz) - (W+1)'(sz);
        end
    end

    // stage 1: scale, half-plane fold, gain product for -dz
    ptpyp_pkg::cordic_state_t yaw_st [0:N];
    logic                     yaw_v  [0:N];
    ptpyp_pkg::cordic_state_t prep_next;
    logic signed [W+1:0]      ndz;
    logic signed [PW-1:0]     prod_next;
    logic                     hz_next, nz_next;

    // side data riding along the yaw and pitch stages
    logic signed [PW-1:0]     vz_reg  [0:N];
    logic                     yhz_reg [0:N];
    logic                     ynz_reg [0:N];
    ptpyp_pkg::angle_t        pyaw_reg [1:N];
    logic                     phz_reg  [1:N];
    logic                     pnz_reg  [1:N];
    logic                     valid1_reg;
    ptpyp_pkg::cordic_state_t prep_reg;

    always_comb begin
        hz_next = (dx_reg != '0) || (dy_reg != '0);
        nz_next = hz_next || (dz_reg != '0);
        prep_next.x = ptpyp_pkg::word_t'(dx_reg) <<< XSH;
        prep_next.y = ptpyp_pkg::word_t'(dy_reg) <<< XSH;
        prep_next.z = '0;
        if (dx_reg < 0) begin
            prep_next.x = -prep_next.x;
            prep_next.y = -prep_next.y;
            prep_next.z = (dy_reg >= 0) ? ptpyp_pkg::DEG180_Q16 : -ptpyp_pkg::DEG180_Q16;
        end
        ndz       = -((W+2)'(dz_reg));
        prod_next = PW'(ndz) * $signed({{(PW-26){1'b0}}, ptpyp_pkg::GAIN_Q24});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (adv) begin
            valid1_reg <= valid0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prep_reg   <= prep_next;
            vz_reg[0]  <= prod_next;
            yhz_reg[0] <= hz_next;
            ynz_reg[0] <= nz_next;
        end
    end

    assign yaw_st[0] = prep_reg;
    assign yaw_v[0]  = valid1_reg;

    // yaw cordic stages
    for (genvar i = 0; i < N; i++) begin : g_yaw
        ptpyp_cordic_stage #(.STEP(i)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (yaw_v[i]),
            .in_state  (yaw_st[i]),
            .out_valid (yaw_v[i+1]),
            .out_state (yaw_st[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < N; i++) begin
                vz_reg[i+1]  <= vz_reg[i];
                yhz_reg[i+1] <= yhz_reg[i];
                ynz_reg[i+1] <= ynz_reg[i];
            end
        end
    end

    // pitch cordic stages, seeded with the horizontal length and scaled -dz
    ptpyp_pkg::cordic_state_t pit_st [0:N];
    logic                     pit_v  [0:N];

    assign pit_st[0].x = yaw_st[N].x;
    assign pit_st[0].y = ptpyp_pkg::word_t'(vz_reg[N]) <<< VSH;
    assign pit_st[0].z = '0;
    assign pit_v[0]    = yaw_v[N];

    for (genvar i = 0; i < N; i++) begin : g_pitch
        ptpyp_cordic_stage #(.STEP(i)) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (adv),
            .in_valid  (pit_v[i]),
            .in_state  (pit_st[i]),
            .out_valid (pit_v[i+1]),
            .out_state (pit_st[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pyaw_reg[1] <= yaw_st[N].z;
            phz_reg[1]  <= yhz_reg[N];
            pnz_reg[1]  <= ynz_reg[N];
            for (int i = 1; i < N; i++) begin
                pyaw_reg[i+1] <= pyaw_reg[i];
                phz_reg[i+1]  <= phz_reg[i];
                pnz_reg[i+1]  <= pnz_reg[i];
            end
        end
    end

    // output stage: zero cases, round half up to 1/128 degree, clamp
    ptpyp_pkg::angle_t yaw_z, pit_z, yaw_r, pit_r;
    logic signed [15:0] yaw_next;
    logic signed [14:0] pitch_next;
    logic               m_tvalid_reg;
    logic signed [15:0] yaw_reg;
    logic signed [14:0] pitch_reg;

    always_comb begin
        yaw_z = phz_reg[N] ? pyaw_reg[N] : '0;
        pit_z = pnz_reg[N] ? pit_st[N].z : '0;
        yaw_r = (yaw_z + 32'sd256) >>> 9;
        pit_r = (pit_z + 32'sd256) >>> 9;
        if (yaw_r > ptpyp_pkg::YAW_LIMIT) begin
            yaw_r = ptpyp_pkg::YAW_LIMIT;
        end else if (yaw_r < -ptpyp_pkg::YAW_LIMIT) begin
            yaw_r = -ptpyp_pkg::YAW_LIMIT;
        end
        if (pit_r > ptpyp_pkg::PITCH_LIMIT) begin
            pit_r = ptpyp_pkg::PITCH_LIMIT;
        end else if (pit_r < -ptpyp_pkg::PITCH_LIMIT) begin
            pit_r = -ptpyp_pkg::PITCH_LIMIT;
        end
        yaw_next   = yaw_r[15:0];
        pitch_next = pit_r[14:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= pit_v[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            yaw_reg   <= yaw_next;
            pitch_reg <= pitch_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, pitch_reg, yaw_reg};

    // checks
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd23040 &&
                      $signed(m_tdata[15:0]) >= -16'sd23040))
        else $error("yaw out of range");

    a_pitch_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[30:16]) <= 15'sd11520 &&
                      $signed(m_tdata[30:16]) >= -15'sd11520))
        else $error("pitch out of range");

    a_stage_to_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && pit_v[N]) |=> m_tvalid)
        else $error("last pitch stage word did not reach output");

endmodule
